FILE: sv/led_strip_pulse_comet_renderer_unit_defines.svh
// ----------------------------------------------------------------------------
// LED strip comet renderer assertion macros
// Shared macros for the concurrent checks of the comet renderer.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_PULSE_COMET_RENDERER_UNIT_DEFINES_SVH
`define LED_STRIP_PULSE_COMET_RENDERER_UNIT_DEFINES_SVH

// Overlapping implication, checked at every rising edge outside reset.
`define LSPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the following cycle.
`define LSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lspc_pkg.sv
// ----------------------------------------------------------------------------
// LED strip comet renderer package
// Shared constants, command and status structs and color helper functions.
// ----------------------------------------------------------------------------
package lspc_pkg;

    localparam int NUM_LEDS_DEF    = 60;
    localparam int PULSE_SLOTS_DEF = 8;
    localparam int TAIL_LEDS_DEF   = 8;
    localparam int FRAME_MS_DEF    = 16;

    localparam int LED_IDX_W = 6;
    localparam int COLOR_W   = 24;
    localparam int POS_W     = 24;
    localparam int SPEED_W   = 22;
    localparam int TIME_W    = 32;
    localparam int TRAV_W    = 16;
    localparam int BPM_W     = 9;
    localparam int LEVEL_W   = 16;
    localparam int QUO_W     = 23;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W    = SPEED_W + POS_W;

    localparam logic [POS_W-1:0]   POS_MAX        = '1;
    localparam logic [SPEED_W-1:0] SPEED_MAX      = '1;
    localparam logic [QUO_W-1:0]   BEAT_MS_NUM    = QUO_W'(60000);
    localparam logic [TRAV_W-1:0]  DEFAULT_TRAV   = TRAV_W'(1000);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_TRAV = 1'b1;

    typedef struct packed {
        logic capture;
        logic slot_clr;
        logic slot_inc;
        logic scan_step;
        logic div_bpm;
        logic div_spd;
        logic trav_load;
        logic trig_commit;
        logic frame_commit;
        logic adv_mul;
        logic adv_wr;
        logic led_clr;
        logic led_inc;
        logic clr_wr;
        logic tail_clr;
        logic tail_inc;
        logic ren_prep;
        logic ren_rd;
        logic ren_half;
        logic ren_wr;
        logic out_rd;
        logic out_emit;
    } dp_cmd_t;

    typedef struct packed {
        logic frame_early;
        logic slot_free;
        logic slot_last;
        logic tail_last;
        logic step_skip;
        logic second_on_strip;
        logic led_last;
        logic bpm_div;
        logic div_busy;
    } dp_status_t;

    // Gradient stops: white, blue, purple, red. Channel 0 is red.
    function automatic logic [7:0] grad_stop(logic [1:0] stop, logic [1:0] chan);
        logic [7:0] val;
        case ({stop, chan})
            4'h0: val = 8'd255;
            4'h1: val = 8'd255;
            4'h2: val = 8'd255;
            4'h4: val = 8'd60;
            4'h5: val = 8'd120;
            4'h6: val = 8'd255;
            4'h8: val = 8'd160;
            4'h9: val = 8'd30;
            4'hA: val = 8'd220;
            4'hC: val = 8'd255;
            4'hD: val = 8'd0;
            4'hE: val = 8'd0;
            default: val = 8'd0;
        endcase
        return val;
    endfunction

    function automatic logic [7:0] grad_blend(logic [1:0] seg, logic [1:0] chan,
                                              logic [7:0] amt);
        logic signed [9:0]  a;
        logic signed [9:0]  b;
        logic signed [9:0]  diff;
        logic signed [19:0] v;
        a    = signed'({2'b00, grad_stop(seg, chan)});
        b    = signed'({2'b00, grad_stop(2'(seg + 2'd1), chan)});
        diff = b - a;
        v    = (20'(a) <<< 8) + 20'(b) + 20'(signed'({1'b0, amt})) * 20'(diff);
        return v[15:8];
    endfunction

    function automatic logic [7:0] vid_scale(logic [7:0] c, logic [7:0] s);
        logic [15:0] prod;
        prod = c * s;
        if (c == 8'd0) begin
            return 8'd0;
        end
        return prod[15:8] + {7'd0, s != 8'd0};
    endfunction

    function automatic logic [7:0] sat_add8(logic [7:0] a, logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8] ? 8'hFF : sum[7:0];
    endfunction

endpackage

FILE: sv/lspc_div.sv
// ----------------------------------------------------------------------------
// LED strip comet renderer divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lspc_div
    import lspc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [QUO_W-1:0]  dividend,
    input  logic [TRAV_W-1:0] divisor,
    output logic              busy,
    output logic [QUO_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(QUO_W + 1);
    localparam int REM_W = TRAV_W + 1;

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [REM_W-1:0] rem_reg;
    logic [TRAV_W-1:0] dsr_reg;
    logic [REM_W-1:0] shifted;
    logic             fits;
    logic [REM_W-1:0] rem_next;

    assign shifted  = {rem_reg[TRAV_W-1:0], quo_reg[QUO_W-1]};
    assign fits     = shifted >= {1'b0, dsr_reg};
    assign rem_next = fits ? shifted - {1'b0, dsr_reg} : shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QUO_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/lspc_ctrl.sv
// ----------------------------------------------------------------------------
// LED strip comet renderer controller
// Sequences trigger, advance, clear, render and output phases.
// ----------------------------------------------------------------------------
module lspc_ctrl
    import lspc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       frame_item,
    input  dp_status_t status,
    output logic       busy,
    output dp_cmd_t    dp_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BPM_DIV,
        ST_BPM_WAIT,
        ST_TRAV,
        ST_SPD_DIV,
        ST_SPD_WAIT,
        ST_COMMIT,
        ST_CHECK,
        ST_ADV_MUL,
        ST_ADV_WR,
        ST_CLEAR,
        ST_PREP,
        ST_RD0,
        ST_WR0,
        ST_RD1,
        ST_WR1,
        ST_OUT_RD,
        ST_OUT_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   step_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        dp_cmd     = '0;
        state_next = state_reg;
        step_done  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    dp_cmd.capture  = 1'b1;
                    dp_cmd.slot_clr = 1'b1;
                    state_next = frame_item ? ST_CHECK : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                dp_cmd.scan_step = 1'b1;
                if (status.slot_free || status.slot_last)
                begin
                    state_next = ST_BPM_DIV;
                end
                else
                begin
                    dp_cmd.slot_inc = 1'b1;
                end
            end
            ST_BPM_DIV:
            begin
                if (status.bpm_div)
                begin
                    dp_cmd.div_bpm = 1'b1;
                    state_next = ST_BPM_WAIT;
                end
                else
                begin
                    state_next = ST_TRAV;
                end
            end
            ST_BPM_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_TRAV;
                end
            end
            ST_TRAV:
            begin
                dp_cmd.trav_load = 1'b1;
                state_next = ST_SPD_DIV;
            end
            ST_SPD_DIV:
            begin
                dp_cmd.div_spd = 1'b1;
                state_next = ST_SPD_WAIT;
            end
            ST_SPD_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                dp_cmd.trig_commit = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CHECK:
            begin
                if (status.frame_early)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    dp_cmd.frame_commit = 1'b1;
                    state_next = ST_ADV_MUL;
                end
            end
            ST_ADV_MUL:
            begin
                dp_cmd.adv_mul = 1'b1;
                state_next = ST_ADV_WR;
            end
            ST_ADV_WR:
            begin
                dp_cmd.adv_wr = 1'b1;
                if (status.slot_last)
                begin
                    dp_cmd.led_clr = 1'b1;
                    state_next = ST_CLEAR;
                end
                else
                begin
                    dp_cmd.slot_inc = 1'b1;
                    state_next = ST_ADV_MUL;
                end
            end
            ST_CLEAR:
            begin
                dp_cmd.clr_wr = 1'b1;
                if (status.led_last)
                begin
                    dp_cmd.slot_clr = 1'b1;
                    dp_cmd.tail_clr = 1'b1;
                    state_next = ST_PREP;
                end
                else
                begin
                    dp_cmd.led_inc = 1'b1;
                end
            end
            ST_PREP:
            begin
                if (status.step_skip)
                begin
                    step_done = 1'b1;
                end
                else
                begin
                    dp_cmd.ren_prep = 1'b1;
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                dp_cmd.ren_rd = 1'b1;
                state_next = ST_WR0;
            end
            ST_WR0:
            begin
                dp_cmd.ren_wr = 1'b1;
                if (status.second_on_strip)
                begin
                    state_next = ST_RD1;
                end
                else
                begin
                    step_done = 1'b1;
                end
            end
            ST_RD1:
            begin
                dp_cmd.ren_rd   = 1'b1;
                dp_cmd.ren_half = 1'b1;
                state_next = ST_WR1;
            end
            ST_WR1:
            begin
                dp_cmd.ren_wr = 1'b1;
                step_done = 1'b1;
            end
            ST_OUT_RD:
            begin
                dp_cmd.out_rd = 1'b1;
                state_next = ST_OUT_EMIT;
            end
            ST_OUT_EMIT:
            begin
                dp_cmd.out_emit = 1'b1;
                dp_cmd.led_inc  = 1'b1;
                state_next = status.led_last ? ST_IDLE : ST_OUT_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Move to the next tail step, the next slot, or on to output.
        if (step_done)
        begin
            if (status.tail_last)
            begin
                dp_cmd.tail_clr = 1'b1;
                if (status.slot_last)
                begin
                    dp_cmd.led_clr = 1'b1;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    dp_cmd.slot_inc = 1'b1;
                    state_next = ST_PREP;
                end
            end
            else
            begin
                dp_cmd.tail_inc = 1'b1;
                state_next = ST_PREP;
            end
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: sv/lspc_datapath.sv
// ----------------------------------------------------------------------------
// LED strip comet renderer datapath
// Slot registers, divider, accumulation memory and result registers.
// ----------------------------------------------------------------------------
module lspc_datapath
    import lspc_pkg::*;
#(
    parameter int NUM_LEDS    = NUM_LEDS_DEF,
    parameter int PULSE_SLOTS = PULSE_SLOTS_DEF,
    parameter int TAIL_LEDS   = TAIL_LEDS_DEF,
    parameter int FRAME_MS    = FRAME_MS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               dp_cmd,
    output dp_status_t            status,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    input  logic [BPM_W-1:0]      beats_per_minute,
    input  logic [LEVEL_W-1:0]    level_fraction,
    input  logic [TIME_W-1:0]     now_ms,
    output logic                  result_strobe,
    output logic [LED_IDX_W-1:0]  led_index,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic                  last_led
);

    localparam int SLOT_W = (PULSE_SLOTS > 1) ? $clog2(PULSE_SLOTS) : 1;
    localparam int LED_W  = $clog2(NUM_LEDS);
    localparam int TAIL_W = $clog2(TAIL_LEDS + 1);
    localparam int FR_W   = $clog2(TAIL_LEDS) + 1;
    localparam int FADE_Q = 255 / TAIL_LEDS;
    localparam int FADE_R = 255 % TAIL_LEDS;
    localparam logic [QUO_W-1:0] SPD_NUM      = QUO_W'(NUM_LEDS * 65536);
    localparam logic [POS_W-1:0] LED_LIMIT    = POS_W'(NUM_LEDS * 65536);
    localparam logic [POS_W-1:0] RETIRE_LIMIT = POS_W'((NUM_LEDS + TAIL_LEDS) * 65536);

    // Configuration.
    logic              speed_mode_reg;
    logic [TRAV_W-1:0] fixed_trav_reg;

    // Captured item.
    logic [BPM_W-1:0]  bpm_reg;
    logic [1:0]        seg_reg;
    logic [7:0]        amt_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] dt_reg;

    // Pulse slots.
    logic               active_reg [PULSE_SLOTS];
    logic [POS_W-1:0]   pos_reg    [PULSE_SLOTS];
    logic [SPEED_W-1:0] speed_reg  [PULSE_SLOTS];
    logic [TIME_W-1:0]  start_reg  [PULSE_SLOTS];
    logic [COLOR_W-1:0] color_reg  [PULSE_SLOTS];
    logic [TIME_W-1:0]  last_frame_reg;

    logic [SLOT_W-1:0] slot_cnt_reg;
    logic [SLOT_W-1:0] chosen_reg;
    logic [TIME_W-1:0] oldest_reg;
    logic [TRAV_W-1:0] trav_reg;

    logic [PROD_W-1:0] prod_reg;
    logic              big_reg;

    logic [TAIL_W-1:0] tail_cnt_reg;
    logic [7:0]        fade_q_reg;
    logic [FR_W-1:0]   fade_r_reg;

    logic [7:0]        v1_reg [3];
    logic [7:0]        v2_reg [3];
    logic [LED_W-1:0]  idx_reg;
    logic [15:0]       f_reg;
    logic [LED_W-1:0]  addr_reg;
    logic [LED_W-1:0]  led_cnt_reg;

    logic [COLOR_W-1:0] acc_mem [NUM_LEDS];
    logic [COLOR_W-1:0] rdata_reg;

    logic               strobe_reg;
    logic [LED_IDX_W-1:0] led_index_reg;
    logic [COLOR_W-1:0] rgb_reg;
    logic               last_led_reg;

    // Divider.
    logic              div_start;
    logic [QUO_W-1:0]  div_dividend;
    logic [TRAV_W-1:0] div_divisor;
    logic              div_busy;
    logic [QUO_W-1:0]  div_quo;

    lspc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign div_start    = dp_cmd.div_bpm | dp_cmd.div_spd;
    assign div_dividend = dp_cmd.div_spd ? SPD_NUM : BEAT_MS_NUM;
    assign div_divisor  = dp_cmd.div_spd ? trav_reg : TRAV_W'(bpm_reg);

    // Level to gradient segment and blend amount.
    logic [17:0] level3;
    logic [23:0] amt_full;
    assign level3   = {2'b00, level_fraction} + {1'b0, level_fraction, 1'b0};
    assign amt_full = {level3[15:0], 8'd0} - {8'd0, level3[15:0]};

    logic bpm_div;
    logic [TRAV_W-1:0] trav_pick;
    assign bpm_div   = speed_mode_reg && (bpm_reg != '0);
    assign trav_pick = bpm_div ? div_quo[TRAV_W-1:0]
                     : (speed_mode_reg ? DEFAULT_TRAV : fixed_trav_reg);

    // Advance.
    logic [POS_W:0]   adv_sum;
    logic             adv_sat;
    logic [POS_W-1:0] adv_pos;
    assign adv_sum = {1'b0, pos_reg[slot_cnt_reg]} + {1'b0, prod_reg[POS_W-1:0]};
    assign adv_sat = big_reg || (prod_reg[PROD_W-1:POS_W] != '0) || adv_sum[POS_W];
    assign adv_pos = adv_sat ? POS_MAX : adv_sum[POS_W-1:0];

    // Render step geometry.
    logic [POS_W:0]     ren_off;
    logic [POS_W:0]     ren_p;
    logic [7:0]         fade;
    logic [COLOR_W-1:0] cur_color;
    logic [16:0]        f_inv;
    logic [24:0]        s0_full;
    logic [23:0]        s1_full;
    logic [7:0]         s_sel;
    logic [LED_W-1:0]   rd_addr;
    logic [FR_W-1:0]    fade_r_sum;
    logic               fade_carry;

    assign ren_off   = (POS_W + 1)'({tail_cnt_reg, 16'd0});
    assign ren_p     = {1'b0, pos_reg[slot_cnt_reg]} - ren_off;
    assign fade      = 8'd255 - fade_q_reg;
    assign cur_color = color_reg[slot_cnt_reg];
    assign f_inv     = 17'h10000 - {1'b0, f_reg};
    assign s0_full   = {f_inv, 8'd0} - {8'd0, f_inv};
    assign s1_full   = {f_reg, 8'd0} - {8'd0, f_reg};
    assign s_sel     = dp_cmd.ren_half ? s1_full[23:16] : s0_full[23:16];
    assign rd_addr   = dp_cmd.ren_half ? idx_reg + 1'b1 : idx_reg;
    assign fade_r_sum = fade_r_reg + FR_W'(FADE_R);
    assign fade_carry = fade_r_sum >= FR_W'(TAIL_LEDS);

    // Accumulation memory ports.
    logic               mem_we;
    logic [LED_W-1:0]   mem_waddr;
    logic [COLOR_W-1:0] mem_wdata;
    logic               mem_re;
    logic [LED_W-1:0]   mem_raddr;
    assign mem_we    = dp_cmd.clr_wr | dp_cmd.ren_wr;
    assign mem_waddr = dp_cmd.clr_wr ? led_cnt_reg : addr_reg;
    assign mem_wdata = dp_cmd.clr_wr ? '0 :
                       {sat_add8(rdata_reg[23:16], v2_reg[0]),
                        sat_add8(rdata_reg[15:8],  v2_reg[1]),
                        sat_add8(rdata_reg[7:0],   v2_reg[2])};
    assign mem_re    = dp_cmd.ren_rd | dp_cmd.out_rd;
    assign mem_raddr = dp_cmd.out_rd ? led_cnt_reg : rd_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            acc_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= acc_mem[mem_raddr];
        end
    end

    // Control and slot state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_mode_reg <= 1'b0;
            fixed_trav_reg <= DEFAULT_TRAV;
            last_frame_reg <= '0;
            slot_cnt_reg   <= '0;
            chosen_reg     <= '0;
            oldest_reg     <= '1;
            tail_cnt_reg   <= '0;
            fade_q_reg     <= '0;
            fade_r_reg     <= '0;
            led_cnt_reg    <= '0;
            strobe_reg     <= 1'b0;
            for (int i = 0; i < PULSE_SLOTS; i++)
            begin
                active_reg[i] <= 1'b0;
                pos_reg[i]    <= '0;
                speed_reg[i]  <= '0;
                start_reg[i]  <= '0;
                color_reg[i]  <= '0;
            end
        end
        else
        begin
            strobe_reg <= dp_cmd.out_emit;

            if (wr_en)
            begin
                case (wr_index)
                    REG_SPEED_MODE: speed_mode_reg <= wr_data[0];
                    REG_FIXED_TRAV: fixed_trav_reg <= wr_data[TRAV_W-1:0];
                    default: ;
                endcase
            end

            if (dp_cmd.slot_clr)
            begin
                slot_cnt_reg <= '0;
                chosen_reg   <= '0;
                oldest_reg   <= '1;
            end
            else if (dp_cmd.slot_inc)
            begin
                slot_cnt_reg <= slot_cnt_reg + 1'b1;
            end

            // Slot choice: the first free slot, else the oldest start time.
            if (dp_cmd.scan_step)
            begin
                if (!active_reg[slot_cnt_reg])
                begin
                    chosen_reg <= slot_cnt_reg;
                end
                else if (start_reg[slot_cnt_reg] < oldest_reg)
                begin
                    chosen_reg <= slot_cnt_reg;
                    oldest_reg <= start_reg[slot_cnt_reg];
                end
            end

            if (dp_cmd.trig_commit)
            begin
                active_reg[chosen_reg] <= 1'b1;
                pos_reg[chosen_reg]    <= '0;
                start_reg[chosen_reg]  <= now_reg;
                speed_reg[chosen_reg]  <= div_quo[QUO_W-1] ? SPEED_MAX
                                                           : div_quo[SPEED_W-1:0];
                color_reg[chosen_reg]  <= {grad_blend(seg_reg, 2'd0, amt_reg),
                                           grad_blend(seg_reg, 2'd1, amt_reg),
                                           grad_blend(seg_reg, 2'd2, amt_reg)};
            end

            if (dp_cmd.frame_commit)
            begin
                last_frame_reg <= now_reg;
            end

            if (dp_cmd.adv_wr && active_reg[slot_cnt_reg])
            begin
                pos_reg[slot_cnt_reg] <= adv_pos;
                if (adv_pos > RETIRE_LIMIT)
                begin
                    active_reg[slot_cnt_reg] <= 1'b0;
                end
            end

            if (dp_cmd.tail_clr)
            begin
                tail_cnt_reg <= '0;
                fade_q_reg   <= '0;
                fade_r_reg   <= '0;
            end
            else if (dp_cmd.tail_inc)
            begin
                // Running floor(255 * t / TAIL_LEDS) as quotient and remainder.
                tail_cnt_reg <= tail_cnt_reg + 1'b1;
                fade_q_reg   <= fade_q_reg + 8'(FADE_Q) + {7'd0, fade_carry};
                fade_r_reg   <= fade_carry ? fade_r_sum - FR_W'(TAIL_LEDS) : fade_r_sum;
            end

            if (dp_cmd.led_clr)
            begin
                led_cnt_reg <= '0;
            end
            else if (dp_cmd.led_inc)
            begin
                led_cnt_reg <= led_cnt_reg + 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            bpm_reg <= beats_per_minute;
            now_reg <= now_ms;
            dt_reg  <= now_ms - last_frame_reg;
            seg_reg <= level3[17:16];
            amt_reg <= amt_full[23:16];
        end
        if (dp_cmd.trav_load)
        begin
            trav_reg <= (trav_pick == '0) ? TRAV_W'(1) : trav_pick;
        end
        if (dp_cmd.adv_mul)
        begin
            prod_reg <= speed_reg[slot_cnt_reg] * dt_reg[POS_W-1:0];
            big_reg  <= (dt_reg[TIME_W-1:POS_W] != '0) && (speed_reg[slot_cnt_reg] != '0);
        end
        if (dp_cmd.ren_prep)
        begin
            idx_reg   <= ren_p[16 +: LED_W];
            f_reg     <= ren_p[15:0];
            v1_reg[0] <= vid_scale(cur_color[23:16], fade);
            v1_reg[1] <= vid_scale(cur_color[15:8], fade);
            v1_reg[2] <= vid_scale(cur_color[7:0], fade);
        end
        if (dp_cmd.ren_rd)
        begin
            addr_reg  <= rd_addr;
            v2_reg[0] <= vid_scale(v1_reg[0], s_sel);
            v2_reg[1] <= vid_scale(v1_reg[1], s_sel);
            v2_reg[2] <= vid_scale(v1_reg[2], s_sel);
        end
        if (dp_cmd.out_emit)
        begin
            led_index_reg <= LED_IDX_W'(led_cnt_reg);
            rgb_reg       <= rdata_reg;
            last_led_reg  <= (led_cnt_reg == LED_W'(NUM_LEDS - 1));
        end
    end

    assign status.frame_early     = dt_reg < TIME_W'(FRAME_MS);
    assign status.slot_free       = !active_reg[slot_cnt_reg];
    assign status.slot_last       = (slot_cnt_reg == SLOT_W'(PULSE_SLOTS - 1));
    assign status.tail_last       = (tail_cnt_reg == TAIL_W'(TAIL_LEDS));
    assign status.step_skip       = !active_reg[slot_cnt_reg] || ren_p[POS_W]
                                    || (ren_p[POS_W-1:0] >= LED_LIMIT);
    assign status.second_on_strip = (idx_reg != LED_W'(NUM_LEDS - 1));
    assign status.led_last        = (led_cnt_reg == LED_W'(NUM_LEDS - 1));
    assign status.bpm_div         = bpm_div;
    assign status.div_busy        = div_busy;

    assign result_strobe = strobe_reg;
    assign led_index     = led_index_reg;
    assign red           = rgb_reg[23:16];
    assign green         = rgb_reg[15:8];
    assign blue          = rgb_reg[7:0];
    assign last_led      = last_led_reg;

endmodule

FILE: sv/led_strip_pulse_comet_renderer_unit.sv
// ----------------------------------------------------------------------------
// LED strip pulse comet renderer
// Beat-triggered comet pulses rendered into per-LED colors, one item at a time.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; cmd selects a beat
// trigger or a frame step. A trigger claims a pulse slot and computes its
// color and speed; it gives no results and keeps the block busy through the
// slot scan and one or two passes through the serial divider (the beat
// interval in beat mode, then the speed). A frame step that comes less than
// FRAME_MS after the last frame is dropped in the check state. Otherwise it
// advances every active slot, clears the color accumulator, renders every
// active pulse one tail light at a time (TAIL_LEDS + 1 lights per pulse),
// and then emits NUM_LEDS results, LED 0 first, each read from the
// accumulator before it goes out, with last_led on the final one. Each
// result is marked by result_strobe, high for exactly one cycle, and stays
// on the output ports until the next one; the receiver cannot stall, so it
// must take every item as it comes. Configuration writes are taken at any
// edge with wr_en high but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module led_strip_pulse_comet_renderer_unit
    import lspc_pkg::*;
#(
    parameter int NUM_LEDS    = NUM_LEDS_DEF,
    parameter int PULSE_SLOTS = PULSE_SLOTS_DEF,
    parameter int TAIL_LEDS   = TAIL_LEDS_DEF,
    parameter int FRAME_MS    = FRAME_MS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  cmd,
    input  logic [BPM_W-1:0]      beats_per_minute,
    input  logic [LEVEL_W-1:0]    level_fraction,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output logic                  result_strobe,
    output logic [LED_IDX_W-1:0]  led_index,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic                  last_led
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // The controller walks the phases; the datapath holds the slot, memory and result state.
    lspc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .frame_item (cmd),
        .status     (dp_status),
        .busy       (busy),
        .dp_cmd     (dp_cmd)
    );

    lspc_datapath #(
        .NUM_LEDS    (NUM_LEDS),
        .PULSE_SLOTS (PULSE_SLOTS),
        .TAIL_LEDS   (TAIL_LEDS),
        .FRAME_MS    (FRAME_MS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .dp_cmd           (dp_cmd),
        .status           (dp_status),
        .wr_en            (wr_en),
        .wr_index         (wr_index),
        .wr_data          (wr_data),
        .beats_per_minute (beats_per_minute),
        .level_fraction   (level_fraction),
        .now_ms           (now_ms),
        .result_strobe    (result_strobe),
        .led_index        (led_index),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .last_led         (last_led)
    );

endmodule

FILE: sv/lspc_checker.sv
// ----------------------------------------------------------------------------
// LED strip comet renderer checker
// Port-level checks on the item handshake and the result sequence.
// ----------------------------------------------------------------------------
`include "led_strip_pulse_comet_renderer_unit_defines.svh"

module lspc_props
    import lspc_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  cmd,
    input logic [BPM_W-1:0]      beats_per_minute,
    input logic [LEVEL_W-1:0]    level_fraction,
    input logic [TIME_W-1:0]     now_ms,
    input logic                  wr_en,
    input logic [CFG_IDX_W-1:0]  wr_index,
    input logic [CFG_DATA_W-1:0] wr_data,
    input logic                  result_strobe,
    input logic [LED_IDX_W-1:0]  led_index,
    input logic [7:0]            red,
    input logic [7:0]            green,
    input logic [7:0]            blue,
    input logic                  last_led
);

    // An accepted item raises busy in the following cycle.
    `LSPC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted item did not raise busy")

    // The final result of a frame is the last LED of the strip.
    `LSPC_ASSERT_IMPLY(a_last_index, clk, rst_n, result_strobe && last_led, led_index == LED_IDX_W'(NUM_LEDS - 1), "last_led on wrong LED")

    // Results inside a frame are never strobed back to back.
    `LSPC_ASSERT_NEXT(a_result_gap, clk, rst_n, result_strobe && !last_led, !result_strobe, "results of a frame too close together")

    // The block stays busy until the final result of a frame is out.
    `LSPC_ASSERT_IMPLY(a_busy_mid_frame, clk, rst_n, result_strobe && !last_led, busy, "block idle in the middle of a frame")

endmodule

bind led_strip_pulse_comet_renderer_unit lspc_props #(.NUM_LEDS(NUM_LEDS)) u_lspc_props (.*);
